// File: hw/rtl/ras_pkg.sv
// ras_pkg: shared types, constants and key ordering for the row argsort block
// no dependencies; imported by ras_cell, row_argsort_core and both bench files
`default_nettype none

package ras_pkg;

  // default row capacity
  localparam int MAX_ROW_DEF = 64;

  // fixed payload widths
  localparam int KEY_W     = 32;
  localparam int IDX_OUT_W = 6;
  localparam int CFG_IDX_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_IS_FLOAT = CFG_IDX_W'(1);

  // top level sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_DRAIN
  } ras_state_t;

  // what every cell of the chain does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SORT,
    CELL_SHIFT
  } cell_mode_t;

  // control broadcast to the whole chain
  typedef struct packed {
    cell_mode_t mode;
    logic       descending;
    logic       key_is_float;
  } ras_ctl_t;

  // nan only exists in float mode
  function automatic logic key_nan(input logic [KEY_W-1:0] k, input logic flt);
    key_nan = flt && (k[30:23] == 8'hFF) && (k[22:0] != 23'd0);
  endfunction

  // map a non-nan key to an unsigned value with the same order
  function automatic logic [KEY_W-1:0] key_rank(input logic [KEY_W-1:0] k,
                                                input logic flt);
    logic [KEY_W-1:0] r;
    if (!flt) begin
      r = k ^ 32'h8000_0000;
    end else if (k[30:0] == 31'd0) begin
      r = 32'h8000_0000;
    end else if (k[31]) begin
      r = ~k;
    end else begin
      r = k | 32'h8000_0000;
    end
    key_rank = r;
  endfunction

  // true when key a must come strictly before key b
  function automatic logic goes_before(input logic [KEY_W-1:0] a,
                                       input logic [KEY_W-1:0] b,
                                       input logic desc, input logic flt);
    logic             na;
    logic             nb;
    logic [KEY_W-1:0] ra;
    logic [KEY_W-1:0] rb;
    logic             res;
    na = key_nan(a, flt);
    nb = key_nan(b, flt);
    ra = key_rank(a, flt);
    rb = key_rank(b, flt);
    if (na || nb) begin
      res = desc ? (na && !nb) : (!na && nb);
    end else begin
      res = desc ? (ra > rb) : (ra < rb);
    end
    goes_before = res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ras_cell.sv
// ras_cell: one cell of the sorting chain, holds one key and its arrival index
// depends on ras_pkg; compares itself with its right neighbor
`default_nettype none

module ras_cell #(
  parameter int IDX_W = 6
) (
  input  wire                       clk,
  input  ras_pkg::ras_ctl_t         ctl,
  // load port
  input  wire                       load_en,
  input  wire [ras_pkg::KEY_W-1:0]  load_key,
  input  wire [IDX_W-1:0]           load_idx,
  // left neighbor
  input  wire [ras_pkg::KEY_W-1:0]  left_key,
  input  wire [IDX_W-1:0]           left_idx,
  input  wire                       left_swap,
  // right neighbor
  input  wire [ras_pkg::KEY_W-1:0]  right_key,
  input  wire [IDX_W-1:0]           right_idx,
  input  wire                       pair_en,
  // own contents
  output logic [ras_pkg::KEY_W-1:0] key,
  output logic [IDX_W-1:0]          idx,
  output logic                      swap
);
  import ras_pkg::*;

  logic [KEY_W-1:0] key_next;
  logic [IDX_W-1:0] idx_next;

  // exchange with the right neighbor only on a strict inversion, keeps ties stable
  assign swap = pair_en && goes_before(right_key, key, ctl.descending, ctl.key_is_float);

  // next contents
  always_comb begin
    key_next = key;
    idx_next = idx;
    case (ctl.mode)
      CELL_LOAD: begin
        if (load_en) begin
          key_next = load_key;
          idx_next = load_idx;
        end
      end
      CELL_SORT: begin
        if (swap) begin
          key_next = right_key;
          idx_next = right_idx;
        end else if (left_swap) begin
          key_next = left_key;
          idx_next = left_idx;
        end
      end
      CELL_SHIFT: begin
        key_next = right_key;
        idx_next = right_idx;
      end
      default: begin
        key_next = key;
        idx_next = idx;
      end
    endcase
  end

  // payload register
  always_ff @(posedge clk) begin
    key <= key_next;
    idx <= idx_next;
  end

endmodule

`default_nettype wire

// File: hw/rtl/row_argsort_core.sv
// row_argsort_core: top level of the row argsort block
// depends on ras_pkg and ras_cell; holds the sequencer and the chain of cells
`default_nettype none

// Usage
//   Keys of one row enter on key_bits, one per cycle, with start high while
//   busy is low; last_in_row marks the final key of the row. Keys past
//   MAX_ROW are dropped and every result of that row carries row_overflow.
//   After the last key the chain runs n odd-even exchange phases (n = keys
//   stored), one phase per cycle, then shifts the row out of cell 0: n
//   results on consecutive cycles, each marked by result_valid for one cycle,
//   row_done on the last. After its last key a row keeps busy high through
//   the n exchange phases and the drain. A new row may start in the cycle
//   that shows the final result. The receiver cannot stall.
//   Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are
//   taken while busy is low, so a row sorts with the mode that stands at its
//   last key; unknown indexes are ignored. Reset (rst, synchronous) clears
//   the row count, the overflow flag, the sequencer and sets ascending
//   integer mode.
module row_argsort_core #(
  parameter int MAX_ROW = ras_pkg::MAX_ROW_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  // key requests
  input  wire                           start,
  output logic                          busy,
  input  wire [ras_pkg::KEY_W-1:0]      key_bits,
  input  wire                           last_in_row,
  // results
  output logic                          result_valid,
  output logic [ras_pkg::KEY_W-1:0]     sorted_key,
  output logic [ras_pkg::IDX_OUT_W-1:0] original_index,
  output logic                          row_done,
  output logic                          row_overflow,
  // configuration writes
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [ras_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire                           cfg_data
);
  import ras_pkg::*;

  localparam int IDX_W = $clog2(MAX_ROW);
  localparam int CNT_W = $clog2(MAX_ROW + 1);

  ras_state_t       state;
  ras_state_t       state_next;
  logic [CNT_W-1:0] count;
  logic             overflow;
  logic [CNT_W-1:0] phase;
  logic [CNT_W-1:0] out_cnt;
  logic             descending;
  logic             key_is_float;
  logic             accept;
  logic             has_room;
  logic [CNT_W-1:0] last_pos;
  ras_ctl_t         ctl;

  logic [KEY_W-1:0] cell_key  [MAX_ROW];
  logic [IDX_W-1:0] cell_idx  [MAX_ROW];
  logic             cell_swap [MAX_ROW];
  logic             pair_en   [MAX_ROW];

  assign accept    = start && !busy;
  assign has_room  = count < CNT_W'(MAX_ROW);
  assign last_pos  = count - CNT_W'(1);
  // mode registers stay fixed while a row sorts and drains
  assign cfg_ready = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && last_in_row) state_next = ST_SORT;
      ST_SORT:  if (phase == last_pos) state_next = ST_DRAIN;
      ST_DRAIN: if (out_cnt == last_pos) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy         = 1'b1;
    ctl.mode     = CELL_HOLD;
    ctl.descending   = descending;
    ctl.key_is_float = key_is_float;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        ctl.mode = CELL_LOAD;
      end
      ST_SORT:  ctl.mode = CELL_SORT;
      ST_DRAIN: ctl.mode = CELL_SHIFT;
      default:  ctl.mode = CELL_HOLD;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      overflow     <= 1'b0;
      phase        <= '0;
      out_cnt      <= '0;
      result_valid <= 1'b0;
      descending   <= 1'b0;
      key_is_float <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == ST_DRAIN);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DESCENDING) descending <= cfg_data;
        if (cfg_index == CFG_KEY_IS_FLOAT) key_is_float <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          phase   <= '0;
          out_cnt <= '0;
          if (accept) begin
            if (has_room) count <= count + CNT_W'(1);
            else overflow <= 1'b1;
          end
        end
        ST_SORT: phase <= phase + CNT_W'(1);
        ST_DRAIN: begin
          out_cnt <= out_cnt + CNT_W'(1);
          if (out_cnt == last_pos) begin
            count    <= '0;
            overflow <= 1'b0;
          end
        end
        default: phase <= '0;
      endcase
    end
  end

  // result register, fed from the head of the chain
  always_ff @(posedge clk) begin
    if (state == ST_DRAIN) begin
      sorted_key     <= cell_key[0];
      original_index <= IDX_OUT_W'(cell_idx[0]);
      row_done       <= (out_cnt == last_pos);
      row_overflow   <= overflow;
    end
  end

  // chain of cells
  for (genvar p = 0; p < MAX_ROW; p++) begin : g_cell
    // neighbor pair p,p+1 exchanges on phases of matching parity, inside the row
    if (p < MAX_ROW - 1) begin : g_pair
      assign pair_en[p] = (state == ST_SORT) && (phase[0] == 1'(p % 2))
                          && (CNT_W'(p + 1) < count);
    end else begin : g_end
      assign pair_en[p] = 1'b0;
    end

    ras_cell #(
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_en   (accept && has_room && (count == CNT_W'(p))),
      .load_key  (key_bits),
      .load_idx  (count[IDX_W-1:0]),
      .left_key  (cell_key[(p == 0) ? 0 : p - 1]),
      .left_idx  (cell_idx[(p == 0) ? 0 : p - 1]),
      .left_swap ((p == 0) ? 1'b0 : cell_swap[(p == 0) ? 0 : p - 1]),
      .right_key (cell_key[(p == MAX_ROW - 1) ? p : p + 1]),
      .right_idx (cell_idx[(p == MAX_ROW - 1) ? p : p + 1]),
      .pair_en   (pair_en[p]),
      .key       (cell_key[p]),
      .idx       (cell_idx[p]),
      .swap      (cell_swap[p])
    );
  end

endmodule

`default_nettype wire

// File: bench/argsort_order_checker.sv
// argsort_order_checker: watches the key, result and register channels of
// row_argsort_core, predicts each sorted row and compares it field by field
// depends on ras_pkg for widths and register indexes
module argsort_order_checker (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  input  wire                           busy,
  input  wire [ras_pkg::KEY_W-1:0]      key_bits,
  input  wire                           last_in_row,
  input  wire                           result_valid,
  input  wire [ras_pkg::KEY_W-1:0]      sorted_key,
  input  wire [ras_pkg::IDX_OUT_W-1:0]  original_index,
  input  wire                           row_done,
  input  wire                           row_overflow,
  input  wire                           cfg_valid,
  input  wire                           cfg_ready,
  input  wire [ras_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire                           cfg_data,
  output int                            mismatches,
  output int                            pending,
  output int                            results_checked
);
  import ras_pkg::*;

  localparam int ROW_CAP = MAX_ROW_DEF;

  // one sorted position of a row
  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [IDX_OUT_W-1:0] idx;
    logic                 done;
    logic                 ovf;
  } sorted_entry_t;

  logic             desc_mode;
  logic             float_mode;
  logic             row_overflowed;
  logic [KEY_W-1:0] row_keys [$];
  sorted_entry_t    sorted_q [$];
  sorted_entry_t    want;

  // nan needs an all-ones exponent and a nonzero fraction, float mode only
  function automatic logic nan_key(input logic [KEY_W-1:0] k);
    return float_mode && (&k[30:23]) && (|k[22:0]);
  endfunction

  // unsigned value that orders like the key; both zeros land on one value
  function automatic logic [KEY_W-1:0] order_value(input logic [KEY_W-1:0] k);
    if (!float_mode) return {~k[31], k[30:0]};
    if (k[30:0] == 31'd0) return {1'b1, 31'd0};
    return k[31] ? ~k : {1'b1, k[30:0]};
  endfunction

  // strict order: equal keys never precede, which keeps arrival order
  function automatic logic precedes(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = nan_key(a);
    b_nan = nan_key(b);
    if (a_nan || b_nan) return desc_mode ? (a_nan && !b_nan) : (b_nan && !a_nan);
    if (desc_mode) return order_value(a) > order_value(b);
    return order_value(a) < order_value(b);
  endfunction

  // stable insertion of every stored key, then queue the row's results
  task automatic sort_row();
    logic [KEY_W-1:0]     keys [$];
    logic [IDX_OUT_W-1:0] order [$];
    sorted_entry_t        e;
    int                   j;
    foreach (row_keys[i]) begin
      j = keys.size();
      while (j > 0 && precedes(row_keys[i], keys[j-1])) j = j - 1;
      keys.insert(j, row_keys[i]);
      order.insert(j, IDX_OUT_W'(i));
    end
    foreach (keys[i]) begin
      e.key  = keys[i];
      e.idx  = order[i];
      e.done = (i == keys.size() - 1);
      e.ovf  = row_overflowed;
      sorted_q = {sorted_q, e};
    end
    row_keys.delete();
    row_overflowed = 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [KEY_W-1:0] exp_v,
                                      input logic [KEY_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // all channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      desc_mode       = 1'b0;
      float_mode      = 1'b0;
      row_overflowed  = 1'b0;
      row_keys.delete();
      sorted_q.delete();
      mismatches      = 0;
      results_checked = 0;
    end else begin
      // result against the oldest prediction
      if (result_valid) begin
        if (sorted_q.size() == 0) begin
          $error("result with nothing expected: sorted_key %h original_index %0d",
                 sorted_key, original_index);
          mismatches++;
        end else begin
          want = sorted_q.pop_front();
          check_field("sorted_key", want.key, sorted_key);
          check_field("original_index", KEY_W'(want.idx), KEY_W'(original_index));
          check_field("row_done", KEY_W'(want.done), KEY_W'(row_done));
          check_field("row_overflow", KEY_W'(want.ovf), KEY_W'(row_overflow));
          results_checked++;
        end
      end
      // register writes, unknown indexes do nothing
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DESCENDING:   desc_mode = cfg_data;
          CFG_KEY_IS_FLOAT: float_mode = cfg_data;
          default: ;
        endcase
      end
      // key request: store or drop, sort on the row's last key
      if (start && !busy) begin
        if (row_keys.size() < ROW_CAP) row_keys = {row_keys, key_bits};
        else row_overflowed = 1'b1;
        if (last_in_row) sort_row();
      end
    end
    pending = sorted_q.size();
  end

endmodule

// File: bench/row_argsort_core_test.sv
// row_argsort_core_test: stimulus and verdict for row_argsort_core
// depends on ras_pkg, row_argsort_core and argsort_order_checker
module row_argsort_core_test;
  import ras_pkg::*;

  localparam int ROW_CAP     = MAX_ROW_DEF;
  localparam int RANDOM_KEYS = 400;
  localparam int PHASE_KEYS  = 50;
  localparam int CYCLE_LIMIT = 200000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [KEY_W-1:0]     key_bits;
  logic                 last_in_row;
  logic                 result_valid;
  logic [KEY_W-1:0]     sorted_key;
  logic [IDX_OUT_W-1:0] original_index;
  logic                 row_done;
  logic                 row_overflow;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic                 cfg_data;

  int               mismatches;
  int               pending;
  int               results_checked;
  int               cycles = 0;
  int               keys_sent = 0;
  int               rows_sent = 0;
  int               long_rows = 0;
  logic [KEY_W-1:0] row_buf [$];
  logic [KEY_W-1:0] dup_pool [4];

  row_argsort_core dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .key_bits(key_bits), .last_in_row(last_in_row),
    .result_valid(result_valid), .sorted_key(sorted_key),
    .original_index(original_index), .row_done(row_done), .row_overflow(row_overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  argsort_order_checker watch (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .key_bits(key_bits), .last_in_row(last_in_row),
    .result_valid(result_valid), .sorted_key(sorted_key),
    .original_index(original_index), .row_done(row_done), .row_overflow(row_overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[row_argsort_core] ERROR");
      $finish;
    end
  end

  // one key request; start stays high when the next key follows at once
  task automatic send_key(input logic [KEY_W-1:0] k, input logic fin, input int gap);
    start       <= 1'b1;
    key_bits    <= k;
    last_in_row <= fin;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    keys_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // send row_buf as one row
  task automatic send_row(input bit burst);
    foreach (row_buf[i])
      send_key(row_buf[i], i == row_buf.size() - 1, burst ? 0 : $urandom_range(0, 12));
    rows_sent++;
    if (row_buf.size() > ROW_CAP) long_rows++;
  endtask

  // register write request, valid left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // both registers in random order, behind a write to an unused index
  task automatic set_mode(input logic desc, input logic flt);
    write_reg(CFG_IDX_W'($urandom_range(2, 15)), 1'($urandom()));
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_DESCENDING, desc);
      write_reg(CFG_KEY_IS_FLOAT, flt);
    end else begin
      write_reg(CFG_KEY_IS_FLOAT, flt);
      write_reg(CFG_DESCENDING, desc);
    end
    cfg_valid <= 1'b0;
  endtask

  // block idle with every predicted result seen
  task automatic wait_drained();
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // key mix: raw bits, repeats, integer extremes, nans, zeros, infinities
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    logic             sgn;
    sgn = 1'($urandom());
    case ($urandom_range(0, 9))
      0, 1, 2, 3: k = $urandom();
      4: k = dup_pool[$urandom_range(0, 3)];
      5: k = KEY_W'($urandom_range(0, 8)) - KEY_W'(4);
      6: begin
        case ($urandom_range(0, 3))
          0: k = 32'h7FFF_FFFF;
          1: k = 32'h8000_0000;
          2: k = 32'h0000_0000;
          default: k = 32'hFFFF_FFFF;
        endcase
      end
      7: k = {sgn, 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
      8: k = {sgn, $urandom_range(0, 1) ? 8'hFF : 8'h00, 23'd0};
      default: k = {sgn, 8'h00, 23'($urandom())};
    endcase
    return k;
  endfunction

  initial begin
    int   phase;
    int   len;
    int   phase_keys;
    int   random_sent;
    logic desc;
    logic flt;
    rst         <= 1'b1;
    start       <= 1'b0;
    key_bits    <= '0;
    last_in_row <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // integer ascending: extremes, a nan pattern as plain integer, repeats
    set_mode(1'b0, 1'b0);
    row_buf = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                32'h0000_0001, 32'h7FC0_0000, 32'hFFFF_FFFF};
    send_row(1'b0);
    // row of a single key
    row_buf = '{32'h1234_5678};
    send_row(1'b1);
    start <= 1'b0;

    // float ascending: both zeros, nans, infinities, ones, a denormal
    wait_drained();
    set_mode(1'b0, 1'b1);
    row_buf = '{32'h0000_0000, 32'h8000_0000, 32'h7FC0_0000, 32'hFF80_0000,
                32'h7F80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'hFFFF_FFFF,
                32'h0000_0001};
    send_row(1'b0);
    start <= 1'b0;

    // float descending: nans first, zeros in arrival order
    wait_drained();
    set_mode(1'b1, 1'b1);
    row_buf = '{32'h8000_0000, 32'h7F80_0001, 32'h3F80_0000, 32'h0000_0000,
                32'hFF80_0000, 32'h7F80_0000, 32'hFFC0_0000, 32'h8000_0001};
    send_row(1'b1);
    start <= 1'b0;

    // random phases, all four modes first, then random modes
    phase       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_KEYS) begin
      if (phase < 4) begin
        desc = phase[0];
        flt  = phase[1];
      end else begin
        desc = 1'($urandom());
        flt  = 1'($urandom());
      end
      wait_drained();
      set_mode(desc, flt);
      dup_pool[0] = $urandom();
      dup_pool[1] = 32'h8000_0000;
      dup_pool[2] = 32'h7FC0_0001;
      dup_pool[3] = $urandom();
      phase_keys = 0;
      while (phase_keys < PHASE_KEYS) begin
        // mostly short rows, some long, a few past capacity
        if (phase_keys == 0 && phase % 3 == 2) begin
          len = ROW_CAP + $urandom_range(1, 8);
        end else begin
          case ($urandom_range(0, 19))
            18: len = $urandom_range(41, ROW_CAP);
            19: len = ROW_CAP + $urandom_range(1, 8);
            14, 15, 16, 17: len = $urandom_range(9, 40);
            default: len = $urandom_range(1, 8);
          endcase
        end
        row_buf.delete();
        repeat (len) row_buf = {row_buf, random_key()};
        send_row($urandom_range(0, 3) == 0);
        phase_keys  += len;
        random_sent += len;
      end
      start <= 1'b0;
      phase++;
    end

    wait_drained();
    repeat (16) @(posedge clk);
    $display("sorted %0d rows from %0d keys, %0d results checked", rows_sent, keys_sent,
             results_checked);
    $display("ascending and descending, integer and float keys, %0d rows past capacity",
             long_rows);
    if (mismatches == 0 && pending == 0) begin
      $display("[row_argsort_core] OK");
    end else begin
      $display("[row_argsort_core] ERROR");
    end
    $finish;
  end

endmodule
